>>> rtl/imbd_pkg.sv
package imbd_pkg;

  // Build limits
  localparam int MESH_INDEX_LIMIT = 65536;
  localparam int WINDOW_DEPTH     = 7;

  localparam int KEY_W     = 64;
  localparam int COUNT_W   = 17;
  localparam int MESH_W    = 16;
  localparam int INDEX_W   = 16;
  localparam int POS_W     = 3;
  localparam int WIN_IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int WIN_CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int LIMIT_W   =
    (($clog2(MESH_INDEX_LIMIT + 1) > COUNT_W) ? $clog2(MESH_INDEX_LIMIT + 1) : COUNT_W) + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_VERTEX = 2'd0,
    CMD_TRI    = 2'd1,
    CMD_QUAD   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef logic [KEY_W-1:0]     key_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [MESH_W-1:0]    mesh_t;
  typedef logic [INDEX_W-1:0]   index_t;
  typedef logic [WIN_CNT_W-1:0] win_cnt_t;

  // Corner of the face emitted at each beat: 0,1,2,2,3,0
  function automatic logic [1:0] face_corner(input logic [POS_W-1:0] pos);
    logic [1:0] c;
    case (pos)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd2;
      3'd4:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  // Repeated quad corners do not introduce a vertex
  function automatic logic corner_fresh(input logic [POS_W-1:0] pos);
    logic f;
    case (pos)
      3'd3:    f = 1'b0;
      3'd5:    f = 1'b0;
      default: f = 1'b1;
    endcase
    return f;
  endfunction

  function automatic count_t sat_add(input count_t cnt, input logic [2:0] inc);
    logic [COUNT_W:0] sum;
    sum = {1'b0, cnt} + (COUNT_W + 1)'(inc);
    return (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
  endfunction

  function automatic win_cnt_t win_add(input win_cnt_t cnt, input logic [2:0] inc);
    logic [WIN_CNT_W+2:0] sum;
    sum = (WIN_CNT_W + 3)'(cnt) + (WIN_CNT_W + 3)'(inc);
    return (sum > (WIN_CNT_W + 3)'(WINDOW_DEPTH)) ? WIN_CNT_W'(WINDOW_DEPTH)
                                                   : sum[WIN_CNT_W-1:0];
  endfunction

endpackage

>>> rtl/imbd_if.sv
interface imbd_cmd_if;
  logic              valid;
  logic              ready;
  imbd_pkg::cmd_e    command;
  imbd_pkg::key_t    vertex_a;
  imbd_pkg::key_t    vertex_b;
  imbd_pkg::key_t    vertex_c;
  imbd_pkg::key_t    vertex_d;

  modport source (output valid, command, vertex_a, vertex_b, vertex_c, vertex_d,
                  input ready);
  modport sink   (input valid, command, vertex_a, vertex_b, vertex_c, vertex_d,
                  output ready);
endinterface

interface imbd_idx_if;
  logic              valid;
  logic              ready;
  imbd_pkg::index_t  vertex_index;
  imbd_pkg::mesh_t   mesh_number;
  logic              appended;
  logic              last;

  modport source (output valid, vertex_index, mesh_number, appended, last,
                  input ready);
  modport sink   (input valid, vertex_index, mesh_number, appended, last,
                  output ready);
endinterface

>>> rtl/indexed_mesh_builder_dedup.sv
// Path: an accepted command is held in the job register, and each of its beats
// then passes through the output register before idx_o presents it.
// Throughput: one result beat per cycle unless idx_o stalls; a vertex gives 1 beat,
// a triangle 3 and a quad 6, set by the single output register draining the job
// register. The next command is taken in the cycle the job sends its last beat.
// Reset (rst_ni low, async): counters, mesh number, window fill and valid flags
// clear; stored keys and payload registers are not reset.
module indexed_mesh_builder_dedup (
  input logic         clk_i,
  input logic         rst_ni,
  imbd_cmd_if.sink    cmd_i,
  imbd_idx_if.source  idx_o
);

  localparam int D = imbd_pkg::WINDOW_DEPTH;

  // ---------------------------------------------------------------------------
  // Mesh state
  // ---------------------------------------------------------------------------
  imbd_pkg::count_t   vc_q, vc_d;      // vertices in current mesh
  imbd_pkg::count_t   ic_q, ic_d;      // indices in current mesh
  imbd_pkg::mesh_t    mesh_q, mesh_d;  // current mesh number
  imbd_pkg::win_cnt_t wv_q, wv_d;      // filled window entries
  imbd_pkg::key_t     keys_q [D];      // newest first
  imbd_pkg::key_t     keys_d [D];

  // ---------------------------------------------------------------------------
  // Job register: one accepted command being expanded into beats
  // ---------------------------------------------------------------------------
  logic                          job_valid_q;
  imbd_pkg::cmd_e                job_cmd_q;
  imbd_pkg::count_t              job_base_q, job_base_d;
  logic                          job_app_q, job_app_d;
  imbd_pkg::mesh_t               job_mesh_q;
  logic [imbd_pkg::POS_W-1:0]    job_pos_q;

  // Output register
  logic                          out_valid_q;
  imbd_pkg::index_t              out_index_q, out_index_d;
  imbd_pkg::mesh_t               out_mesh_q;
  logic                          out_app_q, out_app_d;
  logic                          out_last_q;

  // Handshake
  logic in_acc, load_out, job_last, job_done;

  always_comb begin
    case (job_cmd_q)
      imbd_pkg::CMD_QUAD: job_last = (job_pos_q == imbd_pkg::POS_W'(5));
      imbd_pkg::CMD_TRI:  job_last = (job_pos_q == imbd_pkg::POS_W'(2));
      default:            job_last = 1'b1;
    endcase
  end

  assign load_out    = job_valid_q && (!out_valid_q || idx_o.ready);
  assign job_done    = load_out && job_last;
  assign cmd_i.ready = !job_valid_q || job_done;
  assign in_acc      = cmd_i.valid && cmd_i.ready;

  // ---------------------------------------------------------------------------
  // Dedupe search: all window entries compared in parallel, newest wins
  // ---------------------------------------------------------------------------
  logic                            hit;
  logic [imbd_pkg::WIN_IDX_W-1:0]  hit_pos;
  imbd_pkg::count_t                hit_off, hit_idx;

  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int p = D - 1; p >= 0; p--) begin
      if ((imbd_pkg::WIN_CNT_W'(p) < wv_q) && (keys_q[p] == cmd_i.vertex_a)) begin
        hit     = 1'b1;
        hit_pos = imbd_pkg::WIN_IDX_W'(p);
      end
    end
    hit_off = imbd_pkg::COUNT_W'(hit_pos) + imbd_pkg::count_t'(1);
    hit_idx = (vc_q >= hit_off) ? (vc_q - hit_off) : '0;
  end

  // ---------------------------------------------------------------------------
  // Window shift candidates (keys pushed in order, last pushed lands at 0)
  // ---------------------------------------------------------------------------
  imbd_pkg::key_t sgl_ext  [D + 1];
  imbd_pkg::key_t tri_ext  [D + 3];
  imbd_pkg::key_t quad_ext [D + 4];

  always_comb begin
    sgl_ext[0]  = cmd_i.vertex_a;
    tri_ext[0]  = cmd_i.vertex_c;
    tri_ext[1]  = cmd_i.vertex_b;
    tri_ext[2]  = cmd_i.vertex_a;
    quad_ext[0] = cmd_i.vertex_d;
    quad_ext[1] = cmd_i.vertex_c;
    quad_ext[2] = cmd_i.vertex_b;
    quad_ext[3] = cmd_i.vertex_a;
    for (int j = 0; j < D; j++) begin
      sgl_ext[j + 1]  = keys_q[j];
      tri_ext[j + 3]  = keys_q[j];
      quad_ext[j + 4] = keys_q[j];
    end
  end

  // ---------------------------------------------------------------------------
  // Split test and next state for an accepted command
  // ---------------------------------------------------------------------------
  logic                          is_quad, split;
  logic [2:0]                    nidx, nvert;
  imbd_pkg::count_t              vc_base, ic_base;
  imbd_pkg::win_cnt_t            wv_base;
  logic [imbd_pkg::LIMIT_W-1:0]  ic_need;

  always_comb begin
    is_quad = (cmd_i.command == imbd_pkg::CMD_QUAD);
    nidx    = is_quad ? 3'd6 : 3'd3;
    nvert   = is_quad ? 3'd4 : 3'd3;
    ic_need = imbd_pkg::LIMIT_W'(ic_q) + imbd_pkg::LIMIT_W'(nidx);
    split   = ic_need > imbd_pkg::LIMIT_W'(imbd_pkg::MESH_INDEX_LIMIT);
    vc_base = split ? '0 : vc_q;
    ic_base = split ? '0 : ic_q;
    wv_base = split ? '0 : wv_q;

    vc_d       = vc_q;
    ic_d       = ic_q;
    mesh_d     = mesh_q;
    wv_d       = wv_q;
    keys_d     = keys_q;
    job_base_d = vc_q;
    job_app_d  = 1'b0;

    case (cmd_i.command)
      imbd_pkg::CMD_VERTEX: begin
        ic_d = imbd_pkg::sat_add(ic_q, 3'd1);
        if (hit) begin
          job_base_d = hit_idx;
        end else begin
          job_app_d = 1'b1;
          vc_d      = imbd_pkg::sat_add(vc_q, 3'd1);
          wv_d      = imbd_pkg::win_add(wv_q, 3'd1);
          for (int i = 0; i < D; i++) keys_d[i] = sgl_ext[i];
        end
      end
      imbd_pkg::CMD_TRI, imbd_pkg::CMD_QUAD: begin
        // Mesh number saturates, but a split still clears the mesh
        if (split && (mesh_q != '1)) mesh_d = mesh_q + imbd_pkg::mesh_t'(1);
        job_base_d = vc_base;
        vc_d       = imbd_pkg::sat_add(vc_base, nvert);
        ic_d       = imbd_pkg::sat_add(ic_base, nidx);
        wv_d       = imbd_pkg::win_add(wv_base, nvert);
        for (int i = 0; i < D; i++) keys_d[i] = is_quad ? quad_ext[i] : tri_ext[i];
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Beat payload from job register
  // ---------------------------------------------------------------------------
  logic [imbd_pkg::COUNT_W:0] face_sum;

  always_comb begin
    face_sum = {1'b0, job_base_q}
             + (imbd_pkg::COUNT_W + 1)'(imbd_pkg::face_corner(job_pos_q));
    if (job_cmd_q == imbd_pkg::CMD_VERTEX) begin
      face_sum  = {1'b0, job_base_q};
      out_app_d = job_app_q;
    end else begin
      out_app_d = imbd_pkg::corner_fresh(job_pos_q);
    end
    // Index saturates at the 16-bit range
    out_index_d = (|face_sum[imbd_pkg::COUNT_W:imbd_pkg::INDEX_W]) ? '1
                : face_sum[imbd_pkg::INDEX_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= '0;
      ic_q        <= '0;
      mesh_q      <= '0;
      wv_q        <= '0;
      job_valid_q <= 1'b0;
      job_pos_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        vc_q   <= vc_d;
        ic_q   <= ic_d;
        mesh_q <= mesh_d;
        wv_q   <= wv_d;
      end
      // Unused command is taken and dropped
      if (in_acc && (cmd_i.command != imbd_pkg::CMD_NONE)) begin
        job_valid_q <= 1'b1;
        job_pos_q   <= '0;
      end else if (job_done) begin
        job_valid_q <= 1'b0;
      end else if (load_out) begin
        job_pos_q <= job_pos_q + imbd_pkg::POS_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (idx_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Window keys: no reset, guarded by the fill count
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      keys_q <= keys_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      job_cmd_q  <= cmd_i.command;
      job_base_q <= job_base_d;
      job_app_q  <= job_app_d;
      job_mesh_q <= mesh_d;
    end
    if (load_out) begin
      out_index_q <= out_index_d;
      out_mesh_q  <= job_mesh_q;
      out_app_q   <= out_app_d;
      out_last_q  <= job_last;
    end
  end

  assign idx_o.valid        = out_valid_q;
  assign idx_o.vertex_index = out_index_q;
  assign idx_o.mesh_number  = out_mesh_q;
  assign idx_o.appended     = out_app_q;
  assign idx_o.last         = out_last_q;

`ifndef NO_ASSERTIONS
  // Window fill never passes its depth
  a_win_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wv_q <= imbd_pkg::WIN_CNT_W'(D))
    else $error("window fill count out of range");

  // A busy job never advances past its last beat
  a_job_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (job_pos_q < imbd_pkg::POS_W'(6)))
    else $error("job beat position out of range");

  // An accepted quad becomes a live quad job
  a_quad_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i.command == imbd_pkg::CMD_QUAD))
      |=> (job_valid_q && (job_cmd_q == imbd_pkg::CMD_QUAD) && (job_pos_q == '0)))
    else $error("quad command did not start a job");

  // No command is taken while a job still has beats beyond this one
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && !job_done) |-> !cmd_i.ready)
    else $error("command accepted during unfinished job");
`endif

endmodule
